[sv/bmp24_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types and constants for the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bmp24_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int POS_W = 26;
   localparam int IDX_W = 24;

   localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(54);
   localparam logic [POS_W-1:0] HEADER_LAST  = POS_W'(53);
   localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

   localparam logic [7:0]  SIG_B       = 8'h42;
   localparam logic [7:0]  SIG_M       = 8'h4D;
   localparam logic [15:0] DEPTH_24BPP = 16'd24;

   // header byte offsets of the captured fields
   localparam logic [POS_W-1:0] POS_SIG_LO   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SIG_HI   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_OFF_LO   = POS_W'(10);
   localparam logic [POS_W-1:0] POS_OFF_HI   = POS_W'(13);
   localparam logic [POS_W-1:0] POS_WID_LO   = POS_W'(18);
   localparam logic [POS_W-1:0] POS_WID_HI   = POS_W'(21);
   localparam logic [POS_W-1:0] POS_HGT_LO   = POS_W'(22);
   localparam logic [POS_W-1:0] POS_HGT_HI   = POS_W'(25);
   localparam logic [POS_W-1:0] POS_DEPTH_LO = POS_W'(28);
   localparam logic [POS_W-1:0] POS_DEPTH_HI = POS_W'(29);
   localparam logic [POS_W-1:0] POS_COMP_LO  = POS_W'(30);
   localparam logic [POS_W-1:0] POS_COMP_HI  = POS_W'(33);

   // header word slots
   localparam int HDR_WORDS = 5;
   localparam logic [2:0] SLOT_SIG    = 3'd0; // signature low half, depth high half
   localparam logic [2:0] SLOT_OFFSET = 3'd1;
   localparam logic [2:0] SLOT_WIDTH  = 3'd2;
   localparam logic [2:0] SLOT_HEIGHT = 3'd3;
   localparam logic [2:0] SLOT_COMP   = 3'd4;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_DRAIN
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_HEADER,
      ST_TOO_LARGE,
      ST_SHORT_DATA
   } status_type;

endpackage
`default_nettype wire

[sv/bmp24_stream_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Decodes an uncompressed 24-bit BMP file, one byte per request, into pixels.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports                         Contents
// req      in   req_tvalid/tready/tdata/tlast one file byte, file length, end of file
// rsp      out  rsp_tvalid/tready/tdata/tuser one pixel and/or end-of-file status
//               /tlast
//
// One request per clock; its result (if any) sits in the output register the
// cycle after acceptance. Header arithmetic (line size, image size, fit check,
// first row base) is precomputed by free-running registers while the 20 bytes
// after the last header field stream in.
// Reset clears the phase, counters and the output valid; header words do not reset.
// While rsp_tready is low the held result stays, and req_tready drops only
// when that register is occupied.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder
   import bmp24_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [7:0] data_byte, [33:8] file_length, zero pad
   input  wire logic        req_tlast,   // last_byte

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [23:0] pixel_index, [31:24] blue,
                                         // [39:32] green, [47:40] red,
                                         // [49:48] status, zero pad
   output logic             rsp_tuser,   // pixel_valid
   output logic             rsp_tlast    // done_res
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int LBW = $clog2(3 * MAX_WIDTH + 4);
   localparam int PW  = HW + LBW;
   localparam int FW  = ((PW > 32) ? PW : 32) + 1;
   localparam int RBW = WW + HW;

   // ---------------- state ----------------
   logic [POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic [31:0]      hdr_ff [HDR_WORDS];
   phase_type        phase_ff, phase_in;
   logic [LBW-1:0]   bil_ff, bil_in;
   logic [WW-1:0]    col_ff, col_in;
   logic [HW-1:0]    rows_ff, rows_in;
   logic [IDX_W-1:0] rowbase_ff, rowbase_in;
   logic [15:0]      held_ff, held_in;
   logic [1:0]       chan_ff, chan_in;

   // header-derived values, registered from the captured header words
   logic [LBW-1:0]   w3_ff, line_ff;
   logic [PW-1:0]    prod_ff;
   logic             fit_ff;
   logic [IDX_W-1:0] rbpre_ff;

   // output register
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [7:0]       blue_ff, green_ff, red_ff;
   logic             pv_ff, done_ff;
   status_type       status_ff;

   // ---------------- request fields ----------------
   logic [7:0]       in_byte;
   logic [POS_W-1:0] in_len;
   logic             req_fire;

   assign in_byte    = req_tdata[7:0];
   assign in_len     = req_tdata[33:8];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   logic [31:0]   w_full, h_full, off_full;
   logic [WW-1:0] w_small;
   logic [HW-1:0] h_small;

   assign w_full   = hdr_ff[SLOT_WIDTH];
   assign h_full   = hdr_ff[SLOT_HEIGHT];
   assign off_full = hdr_ff[SLOT_OFFSET];
   assign w_small  = w_full[WW-1:0];
   assign h_small  = h_full[HW-1:0];

   // ---------------- header precompute ----------------
   logic [LBW-1:0] w3_in, w3p3;
   logic [RBW-1:0] rb_prod;
   logic [FW-1:0]  fit_sum;

   assign w3_in   = LBW'({w_small, 1'b0}) + LBW'(w_small);
   assign w3p3    = w3_ff + LBW'(3);
   assign rb_prod = RBW'(w_small) * RBW'(h_small - HW'(1));
   assign fit_sum = FW'(off_full) + FW'(prod_ff);

   always_ff @(posedge clock) begin
      w3_ff    <= w3_in;
      line_ff  <= {w3p3[LBW-1:2], 2'b00};
      prod_ff  <= PW'(h_small) * PW'(line_ff);
      fit_ff   <= fit_sum <= FW'(len_ff);
      rbpre_ff <= IDX_W'(rb_prod);
   end

   // ---------------- header capture ----------------
   logic       cap_en;
   logic [2:0] cap_slot;
   logic [1:0] cap_lane;

   always_comb begin
      cap_en   = 1'b1;
      cap_slot = SLOT_SIG;
      cap_lane = byte_pos_ff[1:0];
      priority if (byte_pos_ff <= POS_SIG_HI) begin
         cap_slot = SLOT_SIG;
         cap_lane = byte_pos_ff[1:0];
      end else if (byte_pos_ff == POS_DEPTH_LO || byte_pos_ff == POS_DEPTH_HI) begin
         cap_slot = SLOT_SIG;
         cap_lane = {1'b1, byte_pos_ff[0]};
      end else if (byte_pos_ff >= POS_OFF_LO && byte_pos_ff <= POS_OFF_HI) begin
         cap_slot = SLOT_OFFSET;
         cap_lane = byte_pos_ff[1:0] - POS_OFF_LO[1:0];
      end else if (byte_pos_ff >= POS_WID_LO && byte_pos_ff <= POS_WID_HI) begin
         cap_slot = SLOT_WIDTH;
         cap_lane = byte_pos_ff[1:0] - POS_WID_LO[1:0];
      end else if (byte_pos_ff >= POS_HGT_LO && byte_pos_ff <= POS_HGT_HI) begin
         cap_slot = SLOT_HEIGHT;
         cap_lane = byte_pos_ff[1:0] - POS_HGT_LO[1:0];
      end else if (byte_pos_ff >= POS_COMP_LO && byte_pos_ff <= POS_COMP_HI) begin
         cap_slot = SLOT_COMP;
         cap_lane = byte_pos_ff[1:0] - POS_COMP_LO[1:0];
      end else begin
         cap_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && phase_ff == PH_HEADER && cap_en) begin
         hdr_ff[cap_slot][{cap_lane, 3'b000} +: 8] <= in_byte;
      end
   end

   // ---------------- header check ----------------
   logic       hdr_end;
   status_type check_st;

   assign hdr_end = phase_ff == PH_HEADER && byte_pos_ff == HEADER_LAST;

   always_comb begin
      priority if (len_ff < HEADER_BYTES
                   || hdr_ff[SLOT_SIG][7:0] != SIG_B
                   || hdr_ff[SLOT_SIG][15:8] != SIG_M
                   || hdr_ff[SLOT_COMP] != 32'd0
                   || hdr_ff[SLOT_SIG][31:16] != DEPTH_24BPP
                   || w_full == 32'd0 || w_full[31]
                   || h_full == 32'd0 || h_full[31]
                   || off_full < 32'(HEADER_BYTES)) begin
         check_st = ST_BAD_HEADER;
      end else if (w_full > 32'(MAX_WIDTH) || h_full > 32'(MAX_HEIGHT)) begin
         check_st = ST_TOO_LARGE;
      end else if (!fit_ff) begin
         check_st = ST_SHORT_DATA;
      end else begin
         check_st = ST_OK;
      end
   end

   // ---------------- pixel events ----------------
   logic          enter_pix, in_pix, data_byte, fire_pix, end_img, line_wrap;
   logic [WW-1:0] col_inc;
   logic [LBW-1:0] bil_inc;

   assign enter_pix = phase_ff == PH_SKIP && {6'd0, byte_pos_ff} == off_full;
   assign in_pix    = phase_ff == PH_PIXELS || enter_pix;
   assign data_byte = bil_ff < w3_ff;
   assign fire_pix  = in_pix && data_byte && chan_ff == 2'd2;
   assign col_inc   = col_ff + WW'(1);
   assign end_img   = fire_pix && rows_ff <= HW'(1) && col_inc == w_small;
   assign bil_inc   = bil_ff + LBW'(1);
   assign line_wrap = bil_inc >= line_ff;

   // ---------------- next phase ----------------
   phase_type phase_mid;

   always_comb begin
      phase_mid = phase_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_end) phase_mid = (check_st == ST_OK) ? PH_SKIP : PH_DRAIN;
         end
         PH_SKIP, PH_PIXELS: begin
            if (end_img)        phase_mid = PH_DRAIN;
            else if (in_pix)    phase_mid = PH_PIXELS;
         end
         PH_DRAIN: phase_mid = PH_DRAIN;
         default:  phase_mid = PH_HEADER;
      endcase
      phase_in = req_tlast ? PH_HEADER : phase_mid;
   end

   // ---------------- datapath and result ----------------
   logic       res_valid, done_c;
   status_type st_c;

   always_comb begin
      byte_pos_in = (byte_pos_ff < POS_MAX) ? byte_pos_ff + POS_W'(1) : byte_pos_ff;
      len_in      = len_ff;
      bil_in      = bil_ff;
      col_in      = col_ff;
      rows_in     = rows_ff;
      rowbase_in  = rowbase_ff;
      held_in     = held_ff;
      chan_in     = chan_ff;
      done_c      = 1'b0;
      st_c        = ST_OK;

      if (phase_ff == PH_HEADER && byte_pos_ff == '0) len_in = in_len;

      if (hdr_end) begin
         if (check_st != ST_OK) begin
            done_c = 1'b1;
            st_c   = check_st;
         end else begin
            bil_in     = '0;
            col_in     = '0;
            rows_in    = h_small;
            rowbase_in = rbpre_ff;
            held_in    = '0;
            chan_in    = 2'd0;
         end
      end

      if (in_pix) begin
         if (data_byte) begin
            unique case (chan_ff)
               2'd0: begin
                  held_in = {8'd0, in_byte};
                  chan_in = 2'd1;
               end
               2'd1: begin
                  held_in = {in_byte, held_ff[7:0]};
                  chan_in = 2'd2;
               end
               default: begin
                  chan_in = 2'd0;
                  col_in  = col_inc;
               end
            endcase
         end
         if (end_img) begin
            done_c = 1'b1;
         end else begin
            bil_in = bil_inc;
            if (line_wrap) begin
               bil_in     = '0;
               col_in     = '0;
               chan_in    = 2'd0;
               rows_in    = (rows_ff != '0) ? rows_ff - HW'(1) : rows_ff;
               rowbase_in = rowbase_ff - IDX_W'(w_small);
            end
         end
      end

      if (req_tlast) begin
         if (!done_c && phase_mid != PH_DRAIN) begin
            done_c = 1'b1;
            st_c   = (phase_mid == PH_HEADER) ? ST_BAD_HEADER : ST_SHORT_DATA;
         end
         byte_pos_in = '0;
         chan_in     = 2'd0;
      end

      res_valid = fire_pix || done_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         len_ff      <= '0;
         phase_ff    <= PH_HEADER;
         bil_ff      <= '0;
         col_ff      <= '0;
         rows_ff     <= '0;
         rowbase_ff  <= '0;
         held_ff     <= '0;
         chan_ff     <= 2'd0;
      end else if (req_fire) begin
         byte_pos_ff <= byte_pos_in;
         len_ff      <= len_in;
         phase_ff    <= phase_in;
         bil_ff      <= bil_in;
         col_ff      <= col_in;
         rows_ff     <= rows_in;
         rowbase_ff  <= rowbase_in;
         held_ff     <= held_in;
         chan_ff     <= chan_in;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         pv_ff     <= fire_pix;
         idx_ff    <= fire_pix ? rowbase_ff + IDX_W'(col_ff) : '0;
         blue_ff   <= fire_pix ? held_ff[7:0] : 8'd0;
         green_ff  <= fire_pix ? held_ff[15:8] : 8'd0;
         red_ff    <= fire_pix ? in_byte : 8'd0;
         done_ff   <= done_c;
         status_ff <= st_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, status_ff, red_ff, green_ff, blue_ff, idx_ff};
   assign rsp_tuser  = pv_ff;
   assign rsp_tlast  = done_ff;

   // ---------------- assertions ----------------
   // a pixel only carries an error when the file ends on that byte too early
   a_pixel_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && status_ff != ST_OK
         |-> rsp_tlast && status_ff == ST_SHORT_DATA)
      else $error("pixel result with unexpected status");

   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> phase_ff == PH_HEADER && byte_pos_ff == '0)
      else $error("end of file did not restart header capture");

   a_line_bound : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXELS |-> bil_ff < line_ff)
      else $error("byte in line beyond padded line size");

   a_error_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff != ST_OK |-> rsp_tlast)
      else $error("error status without end of file");

endmodule
`default_nettype wire
